[rtl/core/aes_dec_pkg.sv]
`timescale 1ns / 1ps

package aes_dec_pkg;

  // Cipher size
  localparam int NUM_ROUNDS = 10;
  localparam int KEY_DEPTH  = NUM_ROUNDS + 1;
  localparam int KEY_AW     = $clog2(KEY_DEPTH);
  localparam int BLOCK_W    = 128;
  localparam int HALF_W     = 64;

  // Command codes (tuser bit 0)
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  // GF(2^8) reduction constant
  localparam logic [7:0] GF_POLY = 8'h1b;

  // Write request into the round key store
  typedef struct packed {
    logic              en;
    logic [KEY_AW-1:0] addr;
    logic [BLOCK_W-1:0] data;
  } key_wr_t;

  localparam logic [7:0] DEC_SBOX [0:255] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  // Multiply by x in GF(2^8)
  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
  endfunction

  // Inverse mix of one column, a0 is the top row
  function automatic logic [31:0] inv_mix_col(input logic [31:0] col);
    logic [7:0] a [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    logic [7:0] x2;
    logic [7:0] x4;
    logic [7:0] x8;
    for (int i = 0; i < 4; i++) begin
      a[i]  = col[31-8*i -: 8];
      x2    = xtime(a[i]);
      x4    = xtime(x2);
      x8    = xtime(x4);
      m9[i] = x8 ^ a[i];
      mb[i] = x8 ^ x2 ^ a[i];
      md[i] = x8 ^ x4 ^ a[i];
      me[i] = x8 ^ x4 ^ x2;
    end
    inv_mix_col = {me[0] ^ mb[1] ^ md[2] ^ m9[3],
                   m9[0] ^ me[1] ^ mb[2] ^ md[3],
                   md[0] ^ m9[1] ^ me[2] ^ mb[3],
                   mb[0] ^ md[1] ^ m9[2] ^ me[3]};
  endfunction

endpackage

[rtl/core/aes_dec_key_store.sv]
`timescale 1ns / 1ps

module aes_dec_key_store
  import aes_dec_pkg::*;
(
  input  logic               clk,
  input  key_wr_t            wr,
  input  logic [KEY_AW-1:0]  rd_addr,
  output logic [BLOCK_W-1:0] rd_key
);

  // High and low key words, one row per round
  logic [HALF_W-1:0] mem_high [KEY_DEPTH];
  logic [HALF_W-1:0] mem_low  [KEY_DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_high[wr.addr] <= wr.data[BLOCK_W-1:HALF_W];
      mem_low[wr.addr]  <= wr.data[HALF_W-1:0];
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rd_key <= {mem_high[rd_addr], mem_low[rd_addr]};
  end

endmodule

[rtl/core/aes_dec_round.sv]
`timescale 1ns / 1ps

module aes_dec_round
  import aes_dec_pkg::*;
(
  input  logic [BLOCK_W-1:0] state_in,
  input  logic [BLOCK_W-1:0] round_key,
  input  logic               last,
  output logic [BLOCK_W-1:0] state_out
);

  logic [7:0]         sb [16];
  logic [BLOCK_W-1:0] keyed;

  // Inverse shift rows and inverse sub bytes; byte b is row b%4, column b/4
  always_comb begin
    for (int col = 0; col < 4; col++) begin
      for (int row = 0; row < 4; row++) begin
        sb[4*col+row] = DEC_SBOX[state_in[BLOCK_W-1-8*(4*((col-row+4)%4)+row) -: 8]];
      end
    end
  end

  // Add round key
  always_comb begin
    for (int b = 0; b < 16; b++) begin
      keyed[BLOCK_W-1-8*b -: 8] = sb[b] ^ round_key[BLOCK_W-1-8*b -: 8];
    end
  end

  // Inverse mix columns, skipped in the final round
  always_comb begin
    for (int col = 0; col < 4; col++) begin
      state_out[BLOCK_W-1-32*col -: 32] = last ? keyed[BLOCK_W-1-32*col -: 32]
                                               : inv_mix_col(keyed[BLOCK_W-1-32*col -: 32]);
    end
  end

endmodule

[rtl/core/aes128_block_decrypt.sv]
`timescale 1ns / 1ps

// AES-128 block decryptor, ECB style.
// Input stream s_*: tuser[0] is the command. A load word (command 0) writes
// round key key_round into the key store and gives no output; indexes above
// the last round are dropped. A decrypt word (command 1) gives one plaintext
// word on m_*. Round keys must be loaded before the first decrypt.
// A decrypt word first has round key 10 added, then runs ten rounds, one at
// a time, through a single round unit, paced by one round-key read per cycle
// from the key store. The next word is taken on the edge the result is
// registered, so a new decrypt word is not taken before the last is done.
// The result waits in an output register; if the receiver stalls, the engine
// holds in its final round and takes no new word until the register frees.
// Reset (rst, synchronous) returns the engine to idle and empties the output
// register. The key store is not cleared.
module aes128_block_decrypt
  import aes_dec_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [135:0] s_tdata,   // key_round[3:0], word_high[67:4], word_low[131:68], zero
  input  logic [0:0]   s_tuser,   // command[0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata    // plain_high[63:0], plain_low[127:64]
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_INIT  = 3'b010,
    ST_ROUND = 3'b100
  } fsm_t;

  localparam logic [KEY_AW-1:0] LAST_KEY = KEY_AW'(NUM_ROUNDS);

  fsm_t               fsm;
  logic [KEY_AW-1:0]  round;
  logic [BLOCK_W-1:0] state;

  logic               accept;
  logic               accept_dec;
  logic               out_free;
  logic               finish;
  logic [3:0]         in_key_round;
  logic [BLOCK_W-1:0] in_block;
  key_wr_t            key_wr;
  logic [KEY_AW-1:0]  rd_addr;
  logic [BLOCK_W-1:0] rd_key;
  logic [BLOCK_W-1:0] round_out;

  // Input unpacking and handshake
  always_comb begin
    in_key_round = s_tdata[3:0];
    in_block     = {s_tdata[67:4], s_tdata[131:68]};
    out_free     = !m_tvalid || m_tready;
    finish       = (fsm == ST_ROUND) && (round == '0) && out_free;
    s_tready     = (fsm == ST_IDLE) || finish;
    accept       = s_tvalid && s_tready;
    accept_dec   = accept && (s_tuser[0] == CMD_DECRYPT);
  end

  // Key load; only taken while the engine is not reading keys
  always_comb begin
    key_wr.en   = accept && (s_tuser[0] == CMD_LOAD) && (in_key_round <= 4'(NUM_ROUNDS));
    key_wr.addr = in_key_round[KEY_AW-1:0];
    key_wr.data = in_block;
  end

  // Key read address, one round ahead of the round unit
  always_comb begin
    priority if (accept_dec) begin
      rd_addr = LAST_KEY;
    end else if (fsm == ST_INIT) begin
      rd_addr = round;
    end else if (fsm == ST_ROUND && round != '0) begin
      rd_addr = round - 1'b1;
    end else begin
      rd_addr = round;
    end
  end

  aes_dec_key_store u_key_store (
    .clk     (clk),
    .wr      (key_wr),
    .rd_addr (rd_addr),
    .rd_key  (rd_key)
  );

  aes_dec_round u_round (
    .state_in  (state),
    .round_key (rd_key),
    .last      (round == '0),
    .state_out (round_out)
  );

  // Control: sequencer, round counter, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      fsm      <= ST_IDLE;
      round    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (finish) begin
        m_tvalid <= 1'b1;
      end
      unique case (fsm)
        ST_IDLE: begin
          if (accept_dec) begin
            fsm   <= ST_INIT;
            round <= LAST_KEY - 1'b1;
          end
        end
        ST_INIT: begin
          fsm <= ST_ROUND;
        end
        ST_ROUND: begin
          if (round != '0) begin
            round <= round - 1'b1;
          end else if (finish) begin
            if (accept_dec) begin
              fsm   <= ST_INIT;
              round <= LAST_KEY - 1'b1;
            end else begin
              fsm <= ST_IDLE;
            end
          end
        end
        default: begin
          fsm <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath: cipher state and output word
  always_ff @(posedge clk) begin
    if (accept_dec) begin
      state <= in_block;
    end else if (fsm == ST_INIT) begin
      state <= state ^ rd_key;
    end else if (fsm == ST_ROUND && round != '0) begin
      state <= round_out;
    end
    if (finish) begin
      m_tdata <= {round_out[HALF_W-1:0], round_out[BLOCK_W-1:HALF_W]};
    end
  end

endmodule

[rtl/core/aes_dec_checker.sv]
`timescale 1ns / 1ps

module aes_dec_checker
  import aes_dec_pkg::*;
(
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [0:0]   s_tuser,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [127:0] m_tdata
);

  // Stalled output word holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word changed while stalled");

  // Engine is busy right after taking a decrypt word
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser[0] == CMD_DECRYPT) |=> !s_tready)
    else $error("input taken during key add");

  // Still busy in the second to last round
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser[0] == CMD_DECRYPT) |=> ##(NUM_ROUNDS-1) !s_tready)
    else $error("input taken before rounds complete");

  // A result appears only at the edge where the engine finishes
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tready))
    else $error("result appeared without engine finishing");

endmodule

bind aes128_block_decrypt aes_dec_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
